### rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// PAT section parser package
// Result kinds, header field types and the result word shared by the parser
// modules.
// ----------------------------------------------------------------------------
package pat_pkg;

   // Kind of a result word.
   typedef enum logic [1:0] {
      KIND_PROGRAM   = 2'd0,
      KIND_NETWORK   = 2'd1,
      KIND_SECTION   = 2'd2,
      KIND_LEN_ERROR = 2'd3
   } pat_kind_type;

   // Width of the section length field and of the byte position counter.
   localparam int unsigned LEN_W = 12;

   // Byte positions of the header fields, counted from the table id byte at zero.
   localparam logic [LEN_W-1:0] POS_LENGTH    = 12'd2;
   localparam logic [LEN_W-1:0] POS_STREAM_ID = 12'd4;
   localparam logic [LEN_W-1:0] POS_VERSION   = 12'd5;
   localparam logic [LEN_W-1:0] POS_SECTION   = 12'd6;
   localparam logic [LEN_W-1:0] POS_LAST_SECT = 12'd7;
   localparam logic [LEN_W-1:0] POS_LOOP      = 12'd8;

   // Shortest legal section length: header remainder plus CRC.
   localparam logic [LEN_W-1:0] MIN_SECTION_LENGTH = 12'd9;

   // One result word.
   typedef struct packed {
      pat_kind_type kind;
      logic [15:0]  prog_num;
      logic [12:0]  pid;
      logic [15:0]  stream_id;
      logic [4:0]   version;
      logic         current_next;
      logic [7:0]   section_index;
      logic [7:0]   last_section_index;
      logic [7:0]   table_kind;
      logic [31:0]  crc_value;
      logic         end_of_section;
   } pat_result_type;

endpackage

### rtl/pat_section_parser.sv
// ----------------------------------------------------------------------------
// PAT section parser
// Parses an MPEG-TS program association table section one byte per word and
// emits program entries, network PIDs, a section end with the CRC, or a
// length error.
// ----------------------------------------------------------------------------
//   Channel | Direction | Word
//   req_    | in        | one section byte with its start flag
//   rsp_    | out       | one result: entry, network PID, section end, error
//
// One byte is taken in every cycle unless a byte waits in the input register.
// A byte sits in the input register, where the decoder works on it, and its
// result lands in the output register, which drives rsp_valid.
// A byte that gives a result waits in the input register while the output
// register is full and not being read; bytes without a result never wait.
// Reset clears the section state; the parser is idle until a start byte.
// ----------------------------------------------------------------------------
module pat_section_parser #(
   parameter int unsigned MAX_SECTION_LENGTH = 1021
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_prog_num,
   output logic [12:0] rsp_pid,
   output logic [15:0] rsp_stream_id,
   output logic [4:0]  rsp_version,
   output logic        rsp_current_next,
   output logic [7:0]  rsp_section_index,
   output logic [7:0]  rsp_last_section_index,
   output logic [7:0]  rsp_table_kind,
   output logic [31:0] rsp_crc_value,
   output logic        rsp_end_of_section
);
   import pat_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   logic           has_result;
   logic           can_load;
   logic           step;
   pat_result_type result;
   pat_result_type out_word;

   // The byte in the input register moves on unless its result must wait.
   assign step      = in_valid_ff && (!has_result || can_load);
   assign req_ready = !in_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_section_start;
      end
   end

   pat_decoder #(
      .MAX_SECTION_LENGTH(MAX_SECTION_LENGTH)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .section_start(in_start_ff),
      .has_result   (has_result),
      .result       (result)
   );

   pat_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && has_result),
      .load_word(result),
      .can_load (can_load),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_word (out_word)
   );

   // Result word onto the ports.
   assign rsp_kind               = out_word.kind;
   assign rsp_prog_num           = out_word.prog_num;
   assign rsp_pid                = out_word.pid;
   assign rsp_stream_id          = out_word.stream_id;
   assign rsp_version            = out_word.version;
   assign rsp_current_next       = out_word.current_next;
   assign rsp_section_index      = out_word.section_index;
   assign rsp_last_section_index = out_word.last_section_index;
   assign rsp_table_kind         = out_word.table_kind;
   assign rsp_crc_value          = out_word.crc_value;
   assign rsp_end_of_section     = out_word.end_of_section;

endmodule

### rtl/pat_decoder.sv
// ----------------------------------------------------------------------------
// PAT byte decoder
// Holds the section state, decodes the byte in the input register and forms
// the result word it causes, if any. State moves on when step is high.
// ----------------------------------------------------------------------------
module pat_decoder #(
   parameter int unsigned MAX_SECTION_LENGTH = 1021
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   section_start,
   output logic                   has_result,
   output pat_pkg::pat_result_type result
);
   import pat_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SECTION_LENGTH);

   logic             active_ff, active_in;
   logic [LEN_W-1:0] position_ff, position_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [23:0]      tail_ff, tail_in;
   logic [7:0]       tid_ff, tid_in;
   logic [15:0]      stream_id_ff, stream_id_in;
   logic [4:0]       version_ff, version_in;
   logic             cur_next_ff, cur_next_in;
   logic [7:0]       section_ff, section_in;
   logic [7:0]       last_sect_ff, last_sect_in;

   logic [LEN_W-1:0] new_length;
   logic             length_bad;
   logic             in_loop;
   logic             at_crc_end;

   // Length field as it stands after the second length byte.
   assign new_length = {tail_ff[3:0], data_byte};
   assign length_bad = (new_length < MIN_SECTION_LENGTH) || (new_length > MAX_LEN);

   // Loop entry ends on every fourth byte while the CRC has not begun.
   assign in_loop    = (position_ff >= POS_LOOP)
                       && ({1'b0, position_ff} + 13'd1 < {1'b0, length_ff});
   assign at_crc_end = ({1'b0, position_ff} == {1'b0, length_ff} + 13'd2);

   // Next state and result for the byte in the input register.
   always_comb begin
      active_in    = active_ff;
      position_in  = position_ff;
      length_in    = length_ff;
      tail_in      = tail_ff;
      tid_in       = tid_ff;
      stream_id_in = stream_id_ff;
      version_in   = version_ff;
      cur_next_in  = cur_next_ff;
      section_in   = section_ff;
      last_sect_in = last_sect_ff;
      has_result   = 1'b0;

      result                    = '0;
      result.kind               = KIND_PROGRAM;
      result.stream_id          = stream_id_ff;
      result.version            = version_ff;
      result.current_next       = cur_next_ff;
      result.section_index      = section_ff;
      result.last_section_index = last_sect_ff;
      result.table_kind         = tid_ff;

      if (section_start) begin
         tid_in      = data_byte;
         tail_in     = {16'd0, data_byte};
         position_in = LEN_W'(1);
         active_in   = 1'b1;
      end else if (active_ff) begin
         tail_in     = {tail_ff[15:0], data_byte};
         position_in = position_ff + LEN_W'(1);
         case (position_ff)
            POS_LENGTH: begin
               length_in = new_length;
               if (length_bad) begin
                  active_in                 = 1'b0;
                  has_result                = 1'b1;
                  result.kind               = KIND_LEN_ERROR;
                  result.stream_id          = '0;
                  result.version            = '0;
                  result.current_next       = 1'b0;
                  result.section_index      = '0;
                  result.last_section_index = '0;
                  result.end_of_section     = 1'b1;
               end
            end
            POS_STREAM_ID: stream_id_in = {tail_ff[7:0], data_byte};
            POS_VERSION: begin
               version_in  = data_byte[5:1];
               cur_next_in = data_byte[0];
            end
            POS_SECTION:   section_in   = data_byte;
            POS_LAST_SECT: last_sect_in = data_byte;
            default: begin
               if (position_ff >= POS_LOOP) begin
                  if (in_loop) begin
                     if (position_ff[1:0] == 2'd3) begin
                        has_result = 1'b1;
                        result.pid = {tail_ff[4:0], data_byte};
                        if (tail_ff[23:8] == 16'd0) begin
                           result.kind = KIND_NETWORK;
                        end else begin
                           result.kind     = KIND_PROGRAM;
                           result.prog_num = tail_ff[23:8];
                        end
                     end
                  end else if (at_crc_end) begin
                     active_in             = 1'b0;
                     has_result            = 1'b1;
                     result.kind           = KIND_SECTION;
                     result.crc_value      = {tail_ff, data_byte};
                     result.end_of_section = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // Section state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         position_ff  <= '0;
         length_ff    <= '0;
         tail_ff      <= '0;
         tid_ff       <= '0;
         stream_id_ff <= '0;
         version_ff   <= '0;
         cur_next_ff  <= 1'b0;
         section_ff   <= '0;
         last_sect_ff <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         position_ff  <= position_in;
         length_ff    <= length_in;
         tail_ff      <= tail_in;
         tid_ff       <= tid_in;
         stream_id_ff <= stream_id_in;
         version_ff   <= version_in;
         cur_next_ff  <= cur_next_in;
         section_ff   <= section_in;
         last_sect_ff <= last_sect_in;
      end
   end

endmodule

### rtl/pat_out_reg.sv
// ----------------------------------------------------------------------------
// PAT result register
// Holds one result word until the downstream side takes it, and reports
// whether a new word can be loaded in this cycle.
// ----------------------------------------------------------------------------
module pat_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  pat_pkg::pat_result_type load_word,
   output logic                   can_load,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pat_pkg::pat_result_type out_word
);
   import pat_pkg::*;

   logic           valid_ff;
   pat_result_type word_ff;

   // The slot is free when empty or being emptied in this cycle.
   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         word_ff <= load_word;
      end
   end

endmodule
